// ===== sv/smbm_pkg.sv =====
// smbm_pkg: shared types and constants for the serial loaded bank mapper
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package smbm_pkg;

   // spacing, in ticks, enforced between accepted writes
   localparam logic [1:0] WRITE_GAP      = 2'd3;
   // serial shifter length
   localparam logic [2:0] SHIFT_LEN      = 3'd5;
   // control register value after hard reset: 16k mode, upper window fixed
   localparam logic [4:0] CONTROL_RESET  = 5'h0C;
   localparam logic [4:0] PRG_FIXED_LAST = 5'h0F;

   localparam int unsigned CSR_ADDR_W    = 4;
   localparam int unsigned CSR_DATA_W    = 32;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_TICK  = 2'd1,
      FUNC_RESET = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // internal register picked by address bits 14..13
   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_CHR_A   = 2'd1,
      SEL_CHR_B   = 2'd2,
      SEL_PRG     = 2'd3
   } reg_sel_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PRG_HIGH_FROM_CHR = 2'd0,
      CSR_RAM_BANK_MASK     = 2'd1,
      CSR_RAM_ENABLE_USED   = 2'd2,
      CSR_RAM_OFF_AT_RESET  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [4:0] prg_bank_low;
      logic [4:0] prg_bank_high;
      logic [4:0] chr_bank_low;
      logic [4:0] chr_bank_high;
      logic [1:0] mirroring;
      logic       ram_enabled;
      logic [1:0] ram_bank;
      logic       write_accepted;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/smbm_ifs.sv =====
// smbm_req_if, smbm_rsp_if: valid/ready channels of the bank mapper
// depends on smbm_pkg
`default_nettype none

interface smbm_req_if import smbm_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] cpu_address;
   logic [7:0]  write_data;

   modport source (output valid, output func, output cpu_address, output write_data,
                   input ready);
   modport sink   (input valid, input func, input cpu_address, input write_data,
                   output ready);
endinterface

interface smbm_rsp_if import smbm_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [4:0] prg_bank_low;
   logic [4:0] prg_bank_high;
   logic [4:0] chr_bank_low;
   logic [4:0] chr_bank_high;
   logic [1:0] mirroring;
   logic       ram_enabled;
   logic [1:0] ram_bank;
   logic       write_accepted;

   modport source (output valid, output prg_bank_low, output prg_bank_high,
                   output chr_bank_low, output chr_bank_high, output mirroring,
                   output ram_enabled, output ram_bank, output write_accepted,
                   input ready);
   modport sink   (input valid, input prg_bank_low, input prg_bank_high,
                   input chr_bank_low, input chr_bank_high, input mirroring,
                   input ram_enabled, input ram_bank, input write_accepted,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/serial_loaded_bank_mapper_unit.sv =====
// serial_loaded_bank_mapper_unit: serially loaded cartridge bank mapper
// depends on smbm_pkg and the channel interfaces in smbm_ifs.sv
//
//   channel  | direction | handshake           | carries
//   ---------+-----------+---------------------+----------------------------------
//   req_chan | in        | valid/ready         | func, cpu_address, write_data
//   rsp_chan | out       | valid/ready         | bank numbers, mirroring, ram, flag
//   csr_*    | in/out    | apb, pready tied hi | four option registers at 4*i
//
// one transaction in, one result out; the state update and the bank decode are a
// single combinational pass from the mapper registers to the result register, or to
// the skid register while a held result waits; a transaction can be taken every
// cycle while the skid register is empty
// a two-deep output (result register plus skid register) keeps req ready while one
// result waits; req ready drops only when both are full
// reset is synchronous active high and restores the mapper state and the options
`default_nettype none

module serial_loaded_bank_mapper_unit import smbm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   smbm_req_if.sink                   req_chan,
   smbm_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // option registers
   logic       prg_high_from_chr_ff;
   logic [4:0] ram_bank_mask_ff;
   logic       ram_enable_used_ff;
   logic       ram_off_at_reset_ff;

   // mapper state
   logic [2:0] shift_count_ff,    shift_count_in;
   logic [4:0] shift_data_ff,     shift_data_in;
   logic [4:0] control_ff,        control_in;
   logic [4:0] chr_a_ff,          chr_a_in;
   logic [4:0] chr_b_ff,          chr_b_in;
   logic [4:0] prg_sel_ff,        prg_sel_in;
   logic       prg_extra_ff,      prg_extra_in;
   logic [1:0] ram_bank_ff,       ram_bank_in;
   logic       ram_enable_ff,     ram_enable_in;
   logic [1:0] gap_count_ff,      gap_count_in;

   // output register and skid stage
   logic       out_valid_ff,  out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff,        out_in;
   result_type skid_ff,       skid_in;

   result_type    result;
   logic          accepted;
   logic          popped;
   logic          csr_write;
   func_type      func;
   reg_sel_type   sel;
   csr_index_type csr_index;
   logic [4:0]    load_value;
   logic [2:0]    count_next;
   logic [4:0]    prg_low_bits;
   logic [4:0]    extra_bit;
   logic          write_ok;

   assign func      = func_type'(req_chan.func);
   assign sel       = reg_sel_type'(req_chan.cpu_address[14:13]);
   assign csr_index = csr_index_type'(csr_paddr[3:2]);

   assign req_chan.ready = !skid_valid_ff;
   assign accepted       = req_chan.valid && req_chan.ready;
   assign popped         = out_valid_ff && rsp_chan.ready;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_high_from_chr_ff <= 1'b0;
         ram_bank_mask_ff     <= '0;
         ram_enable_used_ff   <= 1'b1;
         ram_off_at_reset_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PRG_HIGH_FROM_CHR: prg_high_from_chr_ff <= csr_pwdata[0];
            CSR_RAM_BANK_MASK:     ram_bank_mask_ff     <= csr_pwdata[4:0];
            CSR_RAM_ENABLE_USED:   ram_enable_used_ff   <= csr_pwdata[0];
            CSR_RAM_OFF_AT_RESET:  ram_off_at_reset_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         CSR_PRG_HIGH_FROM_CHR: csr_prdata[0]   = prg_high_from_chr_ff;
         CSR_RAM_BANK_MASK:     csr_prdata[4:0] = ram_bank_mask_ff;
         CSR_RAM_ENABLE_USED:   csr_prdata[0]   = ram_enable_used_ff;
         CSR_RAM_OFF_AT_RESET:  csr_prdata[0]   = ram_off_at_reset_ff;
         default: ;
      endcase
   end

   // ---------------- mapper state update ----------------
   always_comb begin
      shift_count_in = shift_count_ff;
      shift_data_in  = shift_data_ff;
      control_in     = control_ff;
      chr_a_in       = chr_a_ff;
      chr_b_in       = chr_b_ff;
      prg_sel_in     = prg_sel_ff;
      prg_extra_in   = prg_extra_ff;
      ram_bank_in    = ram_bank_ff;
      ram_enable_in  = ram_enable_ff;
      gap_count_in   = gap_count_ff;
      write_ok       = 1'b0;
      load_value     = shift_data_ff;
      count_next     = shift_count_ff + 3'd1;

      // serial bit lands at the current shifter position
      if (req_chan.write_data[0]) begin
         case (shift_count_ff)
            3'd0:    load_value = shift_data_ff | 5'b00001;
            3'd1:    load_value = shift_data_ff | 5'b00010;
            3'd2:    load_value = shift_data_ff | 5'b00100;
            3'd3:    load_value = shift_data_ff | 5'b01000;
            3'd4:    load_value = shift_data_ff | 5'b10000;
            default: load_value = shift_data_ff;
         endcase
      end

      case (func)
         FUNC_WRITE: begin
            // writes too close to the last accepted one are dropped
            if (gap_count_ff == 2'd0) begin
               write_ok     = 1'b1;
               gap_count_in = WRITE_GAP;
               if (req_chan.write_data[7]) begin
                  // shifter reset forces 16k mode, upper window fixed
                  control_in     = control_ff | CONTROL_RESET;
                  shift_count_in = '0;
                  shift_data_in  = '0;
               end else if (count_next >= SHIFT_LEN) begin
                  shift_count_in = '0;
                  shift_data_in  = '0;
                  case (sel)
                     SEL_CONTROL: begin
                        control_in = load_value;
                        if (ram_bank_mask_ff != '0) begin
                           ram_bank_in = chr_a_ff[4:3] & ram_bank_mask_ff[4:3];
                        end
                     end
                     SEL_CHR_A, SEL_CHR_B: begin
                        if (sel == SEL_CHR_A) begin
                           chr_a_in = load_value;
                        end else begin
                           chr_b_in = load_value;
                        end
                        if (ram_bank_mask_ff != '0) begin
                           ram_bank_in = load_value[4:3] & ram_bank_mask_ff[4:3];
                        end
                        if (prg_high_from_chr_ff) begin
                           prg_extra_in = load_value[4];
                        end
                     end
                     default: begin
                        prg_sel_in = load_value;
                        if (ram_enable_used_ff) begin
                           ram_enable_in = !load_value[4];
                        end
                     end
                  endcase
               end else begin
                  shift_count_in = count_next;
                  shift_data_in  = load_value;
               end
            end
         end
         FUNC_TICK: begin
            if (gap_count_ff != 2'd0) begin
               gap_count_in = gap_count_ff - 2'd1;
            end
         end
         FUNC_RESET: begin
            // hard reset item restores the mapper state, options are kept
            shift_count_in = '0;
            shift_data_in  = '0;
            control_in     = CONTROL_RESET;
            chr_a_in       = '0;
            chr_b_in       = '0;
            prg_sel_in     = '0;
            prg_extra_in   = prg_high_from_chr_ff;
            ram_bank_in    = '0;
            ram_enable_in  = !ram_off_at_reset_ff;
            gap_count_in   = '0;
         end
         default: ;
      endcase
   end

   // ---------------- bank decode from the updated state ----------------
   assign extra_bit    = {prg_extra_in, 4'b0000};
   assign prg_low_bits = {1'b0, prg_sel_in[3:0]} | extra_bit;

   always_comb begin
      result = '0;
      if (!control_in[3]) begin
         // 32k mode: even/odd pair
         result.prg_bank_low  = {prg_low_bits[4:1], 1'b0};
         result.prg_bank_high = {prg_low_bits[4:1], 1'b1};
      end else if (control_in[2]) begin
         // switchable at 8000, last bank fixed at c000
         result.prg_bank_low  = prg_low_bits;
         result.prg_bank_high = PRG_FIXED_LAST | extra_bit;
      end else begin
         // first bank fixed at 8000, switchable at c000
         result.prg_bank_low  = extra_bit;
         result.prg_bank_high = prg_low_bits;
      end
      if (control_in[4]) begin
         result.chr_bank_low  = chr_a_in;
         result.chr_bank_high = chr_b_in;
      end else begin
         result.chr_bank_low  = {chr_a_in[4:1], 1'b0};
         result.chr_bank_high = {chr_a_in[4:1], 1'b1};
      end
      result.mirroring      = control_in[1:0];
      result.ram_enabled    = ram_enable_in;
      result.ram_bank       = ram_bank_in;
      result.write_accepted = write_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_count_ff <= '0;
         shift_data_ff  <= '0;
         control_ff     <= CONTROL_RESET;
         chr_a_ff       <= '0;
         chr_b_ff       <= '0;
         prg_sel_ff     <= '0;
         prg_extra_ff   <= 1'b0;
         ram_bank_ff    <= '0;
         ram_enable_ff  <= 1'b1;
         gap_count_ff   <= '0;
      end else if (accepted) begin
         shift_count_ff <= shift_count_in;
         shift_data_ff  <= shift_data_in;
         control_ff     <= control_in;
         chr_a_ff       <= chr_a_in;
         chr_b_ff       <= chr_b_in;
         prg_sel_ff     <= prg_sel_in;
         prg_extra_ff   <= prg_extra_in;
         ram_bank_ff    <= ram_bank_in;
         ram_enable_ff  <= ram_enable_in;
         gap_count_ff   <= gap_count_in;
      end
   end

   // ---------------- result register and skid stage ----------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // no transaction is taken while the skid is full
         if (popped) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accepted) begin
         if (!out_valid_ff || popped) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (popped) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.prg_bank_low   = out_ff.prg_bank_low;
   assign rsp_chan.prg_bank_high  = out_ff.prg_bank_high;
   assign rsp_chan.chr_bank_low   = out_ff.chr_bank_low;
   assign rsp_chan.chr_bank_high  = out_ff.chr_bank_high;
   assign rsp_chan.mirroring      = out_ff.mirroring;
   assign rsp_chan.ram_enabled    = out_ff.ram_enabled;
   assign rsp_chan.ram_bank       = out_ff.ram_bank;
   assign rsp_chan.write_accepted = out_ff.write_accepted;

endmodule

`default_nettype wire

// ===== sv/smbm_checker.sv =====
// smbm_checker: port level checks for serial_loaded_bank_mapper_unit
// depends on smbm_pkg; bound to the top level at the end of this file
`default_nettype none

module smbm_checker import smbm_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire result_type rsp_data
);

   // both output slots are empty right after reset and input is open
   assert property (@(posedge clock) reset |=> (!rsp_valid && req_ready))
      else $error("output not empty after reset");

   // input only backs up when a result is waiting
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   // a stalled result is not withdrawn
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result does not change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
      else $error("result changed while stalled");

endmodule

bind serial_loaded_bank_mapper_unit smbm_checker u_smbm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  ({rsp_chan.prg_bank_low, rsp_chan.prg_bank_high, rsp_chan.chr_bank_low,
                rsp_chan.chr_bank_high, rsp_chan.mirroring, rsp_chan.ram_enabled,
                rsp_chan.ram_bank, rsp_chan.write_accepted})
);

`default_nettype wire

// ===== test/serial_loaded_bank_mapper_unit_checker.sv =====
// serial_loaded_bank_mapper_unit_checker: tracks the mapper state and options from
// the accepted transactions and checks every result on the rsp channel
// depends on smbm_pkg and the channel interfaces in smbm_ifs.sv

module serial_loaded_bank_mapper_unit_checker import smbm_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   smbm_req_if                        req_mon,
   smbm_rsp_if                        rsp_mon,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                  csr_pready,
   output int unsigned                mismatch_total,
   output int unsigned                results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       prg_hi_from_chr;
      logic [4:0] ram_mask;
      logic       ram_en_used;
      logic       ram_off_rst;
   } options_type;

   typedef struct packed {
      logic [2:0] shift_count;
      logic [4:0] shift_bits;
      logic [4:0] control;
      logic [4:0] chr_a;
      logic [4:0] chr_b;
      logic [4:0] prg;
      logic       prg_extra;
      logic [1:0] ram_bank;
      logic       ram_en;
      logic [1:0] gap;
   } mapper_state_type;

   localparam options_type OPTIONS_RESET = '{1'b0, 5'd0, 1'b1, 1'b0};

   options_type      opts;
   mapper_state_type mstate;
   result_type       owed_q[$];
   int unsigned      error_count = 0;
   int unsigned      result_index = 0;

   function automatic mapper_state_type cold_state(input options_type o);
      mapper_state_type s;
      s = '0;
      s.control   = CONTROL_RESET;
      s.prg_extra = o.prg_hi_from_chr;
      s.ram_en    = !o.ram_off_rst;
      return s;
   endfunction

   function automatic logic [1:0] ram_bank_of(input logic [4:0] chr, input logic [4:0] mask);
      logic [4:0] picked;
      picked = chr & mask;
      return picked[4:3];
   endfunction

   // one transaction against the mapper state; the fifth serial bit loads a register
   function automatic mapper_state_type advance_mapper(input mapper_state_type s,
         input options_type o, input func_type f, input logic [15:0] addr,
         input logic [7:0] data, output logic accepted);
      logic [4:0] loaded;
      accepted = 1'b0;
      case (f)
         FUNC_WRITE: begin
            if (s.gap == 0) begin
               accepted = 1'b1;
               s.gap = WRITE_GAP;
               if (data[7]) begin
                  s.control     = s.control | CONTROL_RESET;
                  s.shift_count = '0;
                  s.shift_bits  = '0;
               end else begin
                  if (data[0])
                     s.shift_bits[s.shift_count] = 1'b1;
                  s.shift_count = s.shift_count + 3'd1;
                  if (s.shift_count == SHIFT_LEN) begin
                     loaded = s.shift_bits;
                     case (reg_sel_type'(addr[14:13]))
                        SEL_CONTROL: begin
                           s.control = loaded;
                           if (o.ram_mask != 0)
                              s.ram_bank = ram_bank_of(s.chr_a, o.ram_mask);
                        end
                        SEL_CHR_A, SEL_CHR_B: begin
                           if (reg_sel_type'(addr[14:13]) == SEL_CHR_A)
                              s.chr_a = loaded;
                           else
                              s.chr_b = loaded;
                           if (o.ram_mask != 0)
                              s.ram_bank = ram_bank_of(loaded, o.ram_mask);
                           if (o.prg_hi_from_chr)
                              s.prg_extra = loaded[4];
                        end
                        default: begin
                           s.prg = loaded;
                           if (o.ram_en_used)
                              s.ram_en = !loaded[4];
                        end
                     endcase
                     s.shift_count = '0;
                     s.shift_bits  = '0;
                  end
               end
            end
         end
         FUNC_TICK: begin
            if (s.gap != 0)
               s.gap = s.gap - 2'd1;
         end
         FUNC_RESET: s = cold_state(o);
         default: ;
      endcase
      return s;
   endfunction

   // bank decode from the state after the transaction
   function automatic result_type decode_banks(input mapper_state_type s,
         input logic accepted);
      result_type r;
      logic [4:0] ext, sel;
      ext = {s.prg_extra, 4'h0};
      sel = {1'b0, s.prg[3:0]};
      if (!s.control[3]) begin
         r.prg_bank_low  = (sel | ext) & 5'h1E;
         r.prg_bank_high = r.prg_bank_low | 5'h01;
      end else if (s.control[2]) begin
         r.prg_bank_low  = sel | ext;
         r.prg_bank_high = PRG_FIXED_LAST | ext;
      end else begin
         r.prg_bank_low  = ext;
         r.prg_bank_high = sel | ext;
      end
      if (s.control[4]) begin
         r.chr_bank_low  = s.chr_a;
         r.chr_bank_high = s.chr_b;
      end else begin
         r.chr_bank_low  = s.chr_a & 5'h1E;
         r.chr_bank_high = r.chr_bank_low | 5'h01;
      end
      r.mirroring      = s.control[1:0];
      r.ram_enabled    = s.ram_en;
      r.ram_bank       = s.ram_bank;
      r.write_accepted = accepted;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mapper check: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input int unsigned got,
         input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                   result_index, field, got, want));
   endtask

   always @(posedge clock) begin : monitor
      result_type got, want;
      logic       accepted;
      if (reset) begin
         opts   = OPTIONS_RESET;
         mstate = cold_state(OPTIONS_RESET);
         owed_q.delete();
      end else begin
         // results first, so a result never meets the transaction of its own edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.prg_bank_low, rsp_mon.prg_bank_high, rsp_mon.chr_bank_low,
                    rsp_mon.chr_bank_high, rsp_mon.mirroring, rsp_mon.ram_enabled,
                    rsp_mon.ram_bank, rsp_mon.write_accepted};
            if (owed_q.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_index));
            end else begin
               want = owed_q.pop_front();
               check_field("prg_bank_low", 32'(got.prg_bank_low),
                           32'(want.prg_bank_low));
               check_field("prg_bank_high", 32'(got.prg_bank_high),
                           32'(want.prg_bank_high));
               check_field("chr_bank_low", 32'(got.chr_bank_low),
                           32'(want.chr_bank_low));
               check_field("chr_bank_high", 32'(got.chr_bank_high),
                           32'(want.chr_bank_high));
               check_field("mirroring", 32'(got.mirroring), 32'(want.mirroring));
               check_field("ram_enabled", 32'(got.ram_enabled), 32'(want.ram_enabled));
               check_field("ram_bank", 32'(got.ram_bank), 32'(want.ram_bank));
               check_field("write_accepted", 32'(got.write_accepted),
                           32'(want.write_accepted));
            end
            result_index++;
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[3:2]))
               CSR_PRG_HIGH_FROM_CHR: opts.prg_hi_from_chr = csr_pwdata[0];
               CSR_RAM_BANK_MASK:     opts.ram_mask        = csr_pwdata[4:0];
               CSR_RAM_ENABLE_USED:   opts.ram_en_used     = csr_pwdata[0];
               default:               opts.ram_off_rst     = csr_pwdata[0];
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            mstate = advance_mapper(mstate, opts, func_type'(req_mon.func),
                                    req_mon.cpu_address, req_mon.write_data, accepted);
            owed_q.push_back(decode_banks(mstate, accepted));
         end
      end
      results_owed   <= owed_q.size();
      mismatch_total <= error_count;
   end

endmodule

// ===== test/serial_loaded_bank_mapper_unit_tb.sv =====
// serial_loaded_bank_mapper_unit_tb: stimulus and verdict for the bank mapper
// depends on smbm_pkg, smbm_ifs.sv, the mapper rtl and the checker module

module serial_loaded_bank_mapper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smbm_pkg::*;

   localparam int unsigned CLOCK_PERIOD     = 10;
   // result register plus skid register: two held at most
   localparam int unsigned RESULT_LATENCY   = 2;
   // receiver hold-off long enough to fill both output slots and stall req
   localparam int unsigned LONG_HOLD_CYCLES = 60;
   // cycles with no transaction on either channel before giving up
   localparam int unsigned WATCHDOG_LIMIT   = 2000;
   localparam int unsigned PHASE_ITEMS      = 125;

   // receiver stall patterns
   typedef enum logic [1:0] {
      RSP_ALWAYS,
      RSP_COIN,
      RSP_SPARSE,
      RSP_EVERY_FOURTH
   } rsp_mode_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic        long_hold_go;
   int unsigned mismatch_total;
   int unsigned results_owed;

   // sender bookkeeping
   int unsigned burst_left = 0;
   bit          steady     = 1'b0;
   int unsigned items_sent = 0;

   smbm_req_if req_chan ();
   smbm_rsp_if rsp_chan ();

   serial_loaded_bank_mapper_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   serial_loaded_bank_mapper_unit_checker mapper_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_total (mismatch_total),
      .results_owed   (results_owed)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // mostly a cartridge-space address, now and then one below 8000
   function automatic logic [15:0] random_address();
      logic [15:0] addr;
      addr = 16'($urandom);
      if ($urandom_range(0, 15) != 0)
         addr[15] = 1'b1;
      return addr;
   endfunction

   // offer one transaction and hold it until the mapper takes it; the sender runs
   // in bursts and may drop valid for a random gap before a new burst
   task automatic send_item(input func_type f, input logic [15:0] addr,
         input logic [7:0] data);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (!steady && gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.func        <= f;
      req_chan.cpu_address <= addr;
      req_chan.write_data  <= data;
      do @(posedge clock); while (!req_chan.ready);
      if (f != FUNC_NONE)
         items_sent++;
   endtask

   // five serial writes, lsb first; only the fifth address picks the register.
   // a sloppy load may space writes too closely or slip in a shifter reset
   task automatic serial_load(input logic [15:0] addr, input logic [4:0] value,
         input bit sloppy);
      int unsigned bit_pos, ticks;
      for (bit_pos = 0; bit_pos < 5; bit_pos++) begin
         if (sloppy && $urandom_range(0, 24) == 0) begin
            send_item(FUNC_WRITE, random_address(), 8'($urandom) | 8'h80);
            repeat (WRITE_GAP) send_item(FUNC_TICK, 16'($urandom), 8'($urandom));
         end
         send_item(FUNC_WRITE, (bit_pos == 4) ? addr : random_address(),
                   {1'b0, 6'($urandom), value[bit_pos]});
         ticks = 32'(WRITE_GAP);
         if (sloppy && $urandom_range(0, 5) == 0)
            ticks = $urandom_range(0, 32'(WRITE_GAP) - 1);
         else if ($urandom_range(0, 5) == 0)
            ticks += $urandom_range(1, 3);
         repeat (ticks) send_item(FUNC_TICK, 16'($urandom), 8'($urandom));
      end
   endtask

   // drop valid and let every outstanding result come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 1) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready; psel stays up between
   // back-to-back writes
   task automatic write_option(input csr_index_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic set_options(input logic prg_hi, input logic [4:0] mask,
         input logic en_used, input logic off_rst);
      write_option(CSR_PRG_HIGH_FROM_CHR, 32'(prg_hi));
      write_option(CSR_RAM_BANK_MASK, 32'(mask));
      write_option(CSR_RAM_ENABLE_USED, 32'(en_used));
      write_option(CSR_RAM_OFF_AT_RESET, 32'(off_rst));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // a phase opens with a hard reset so the reset-time options take effect, then
   // mostly well-formed serial loads with noise between them
   task automatic random_phase(input int unsigned count);
      int unsigned start, pick;
      start = items_sent;
      send_item(FUNC_RESET, 16'($urandom), 8'($urandom));
      while (items_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            serial_load(random_address(), 5'($urandom), 1'b1);
         else if (pick < 80)
            repeat ($urandom_range(1, 4)) send_item(FUNC_TICK, 16'($urandom), 8'($urandom));
         else if (pick < 92)
            send_item(FUNC_WRITE, 16'($urandom), 8'($urandom));
         else if (pick < 96)
            send_item(FUNC_NONE, 16'($urandom), 8'($urandom));
         else if (pick < 99)
            send_item(FUNC_WRITE, random_address(), 8'($urandom) | 8'h80);
         else
            send_item(FUNC_RESET, 16'($urandom), 8'($urandom));
      end
   endtask

   // receiver: switches among randomly picked stall patterns, plus one long hold-off on request
   initial begin : rsp_stall
      rsp_mode_type mode;
      int unsigned  left, beat;
      bit           hold_taken;
      rsp_chan.ready <= 1'b0;
      mode = RSP_ALWAYS;
      left = 0;
      beat = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         if (left == 0) begin
            mode = rsp_mode_type'($urandom_range(0, 3));
            left = $urandom_range(10, 150);
         end
         left--;
         beat++;
         case (mode)
            RSP_ALWAYS:  rsp_chan.ready <= 1'b1;
            RSP_COIN:    rsp_chan.ready <= 1'($urandom_range(0, 1));
            RSP_SPARSE:  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_chan.ready <= (beat % 4 == 0);
         endcase
      end
   end

   // watchdog: too long without a transaction on either channel
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("serial_loaded_bank_mapper_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      // every input known from time zero
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.func        <= FUNC_TICK;
      req_chan.cpu_address <= '0;
      req_chan.write_data  <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      long_hold_go         <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: default options after reset
      // tick while the gap count is already zero
      send_item(FUNC_TICK, 16'h0000, 8'h00);
      // shifter reset with every data bit set
      send_item(FUNC_WRITE, 16'h8000, 8'hFF);
      // too close to the previous write, so ignored
      send_item(FUNC_WRITE, 16'hFFFF, 8'h01);
      repeat (WRITE_GAP) send_item(FUNC_TICK, 16'hFFFF, 8'hFF);
      // unused function code
      send_item(FUNC_NONE, 16'hFFFF, 8'hFF);
      // load below 8000; bits 14..13 still pick the program register
      serial_load(16'h6000, 5'h1F, 1'b0);
      send_item(FUNC_WRITE, 16'h8000, 8'h00);
      send_item(FUNC_RESET, 16'hFFFF, 8'hFF);

      random_phase(PHASE_ITEMS);
      drain();

      set_options(1'b1, 5'd24, 1'b0, 1'b1);
      random_phase(PHASE_ITEMS);
      drain();

      // back-pressure phase: the receiver holds off while the sender never idles
      set_options(1'b1, 5'd8, 1'b1, 1'b0);
      long_hold_go <= 1'b1;
      steady = 1'b1;
      random_phase(PHASE_ITEMS);
      steady = 1'b0;
      drain();

      set_options(1'b0, 5'd16, 1'b1, 1'b1);
      random_phase(PHASE_ITEMS);
      drain();

      set_options(1'($urandom), 5'($urandom_range(0, 24)), 1'($urandom), 1'($urandom));
      random_phase(PHASE_ITEMS);
      drain();

      set_options(1'b1, 5'($urandom_range(0, 24)), 1'($urandom), 1'($urandom));
      random_phase(PHASE_ITEMS);
      drain();

      set_options(1'b0, 5'd0, 1'b0, 1'b0);
      random_phase(PHASE_ITEMS);
      drain();

      if (mismatch_total == 0)
         $display("serial_loaded_bank_mapper_unit regression: pass");
      else
         $display("serial_loaded_bank_mapper_unit regression: fail");
      $finish;
   end

endmodule
